/* sv/srsg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared types and constants for the stepper ramp step generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_POSITION = 2'd1,
    OP_JOG      = 2'd2,
    OP_SETPOS   = 2'd3
  } op_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE_HALF  = 2'd0;
  localparam logic [1:0] REG_RAMP_LIMIT = 2'd1;
  localparam logic [1:0] REG_DECEL_DIST = 2'd2;
  localparam logic [1:0] REG_DIR_INV    = 2'd3;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int HALF_BITS     = 16;
  localparam int RAMP_BITS     = 18;

  localparam logic [15:0] BASE_HALF_RST  = 16'd1000;
  localparam logic [15:0] RAMP_LIMIT_RST = 16'd400;
  localparam logic [15:0] DECEL_DIST_RST = 16'd500;

  localparam logic signed [RAMP_BITS-1:0] RAMP_MAX = 18'sh1FFFF;
  localparam logic signed [RAMP_BITS-1:0] RAMP_MIN = 18'sh20000;

  typedef struct packed {
    logic [15:0] base_half_period;
    logic [15:0] ramp_limit_half;
    logic [15:0] decel_distance;
    logic        dir_invert;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic               jog_dir;
    logic               jog_hold;
    logic               limit_plus;
    logic               limit_minus;
  } in_item_t;

  typedef struct packed {
    logic                 step;
    logic                 direction;
    logic [HALF_BITS-1:0] half_period;
    logic signed [31:0]   position;
    logic                 done_res;
  } out_item_t;

endpackage

/* sv/srsg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_in_if
// Valid/ready channel that carries one step slot request.
// ----------------------------------------------------------------------------
interface srsg_in_if import srsg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/srsg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_out_if
// Valid/ready channel that carries one step slot result.
// ----------------------------------------------------------------------------
interface srsg_out_if import srsg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/stepper_ramp_step_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator
// Trapezoidal ramp stepper step generator, one result per slot request.
// ----------------------------------------------------------------------------
// Each accepted request yields exactly one result. The block takes one request
// per clock cycle while the output is not held back: a request is held in
// an input register, evaluated combinationally by the slot logic, which also
// updates the position, target, ramp and done state, and lands in a result
// register. While a result waits to be taken, one further request can still
// be accepted into the input register. Configuration writes take effect on the
// next evaluated request and should be made while no request is in flight.
module stepper_ramp_step_generator import srsg_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  srsg_in_if.sink                  in_ch,
  srsg_out_if.source               out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int PB = POSITION_BITS;

  cfg_t                        cfg;
  in_item_t                    in_item_r;
  logic                        in_vld_r;
  out_item_t                   out_r;
  logic                        out_vld_r;
  logic [PB-1:0]               pos_r;
  logic [PB-1:0]               tgt_r;
  logic signed [RAMP_BITS-1:0] ramp_r;
  logic                        done_r;
  logic [PB-1:0]               pos_nxt;
  logic [PB-1:0]               tgt_nxt;
  logic signed [RAMP_BITS-1:0] ramp_nxt;
  logic                        done_nxt;
  out_item_t                   res;
  logic                        adv;
  logic                        in_rdy;

  srsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srsg_slot #(
    .POSITION_BITS (PB)
  ) u_slot (
    .item     (in_item_r),
    .cfg      (cfg),
    .pos      (pos_r),
    .tgt      (tgt_r),
    .ramp     (ramp_r),
    .done     (done_r),
    .pos_nxt  (pos_nxt),
    .tgt_nxt  (tgt_nxt),
    .ramp_nxt (ramp_nxt),
    .done_nxt (done_nxt),
    .res      (res)
  );

  // The result register moves whenever it is empty or being taken.
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_rdy       = !in_vld_r || adv;
  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  // Control state and axis state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      tgt_r     <= '0;
      ramp_r    <= '0;
      done_r    <= 1'b1;
    end else begin
      if (in_rdy) in_vld_r <= in_ch.valid;
      if (adv) out_vld_r <= in_vld_r;
      if (in_vld_r && adv) begin
        pos_r  <= pos_nxt;
        tgt_r  <= tgt_nxt;
        ramp_r <= ramp_nxt;
        done_r <= done_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) in_item_r <= in_ch.data;
    if (in_vld_r && adv) out_r <= res;
  end

  // A load arms the move, clears the ramp and produces a stepless result.
  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv && (in_item_r.op == OP_LOAD)) |=>
      (!done_r && (ramp_r == '0) && out_vld_r && !out_r.step))
    else $error("load did not arm the move");

  // A finished move issues no step until it is rearmed.
  a_done_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv && done_r && (in_item_r.op != OP_LOAD)) |=> !out_r.step)
    else $error("step issued while move done");

  // A slot moves the position by at most one count.
  a_pos_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv && ((in_item_r.op == OP_POSITION) || (in_item_r.op == OP_JOG))) |=>
      ((pos_r == $past(pos_r)) || (pos_r == $past(pos_r) + PB'(1)) ||
       (pos_r == $past(pos_r) - PB'(1))))
    else $error("position jumped by more than one");

  // Results without a step carry no period or direction.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.step) |-> ((out_r.half_period == '0) && !out_r.direction))
    else $error("stepless result carries period or direction");

  // Input stalls only when both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && out_vld_r && !out_ch.ready))
    else $error("input stalled without backpressure");

endmodule

/* sv/srsg_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_cfg
// APB-style register file holding the ramp and direction settings.
// ----------------------------------------------------------------------------
module srsg_cfg import srsg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register writes complete in the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_half_period <= BASE_HALF_RST;
      cfg_r.ramp_limit_half  <= RAMP_LIMIT_RST;
      cfg_r.decel_distance   <= DECEL_DIST_RST;
      cfg_r.dir_invert       <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_HALF:  cfg_r.base_half_period <= pwdata[15:0];
        REG_RAMP_LIMIT: cfg_r.ramp_limit_half  <= pwdata[15:0];
        REG_DECEL_DIST: cfg_r.decel_distance   <= pwdata[15:0];
        REG_DIR_INV:    cfg_r.dir_invert       <= pwdata[0];
        default:        cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      REG_BASE_HALF:  prdata = {16'd0, cfg_r.base_half_period};
      REG_RAMP_LIMIT: prdata = {16'd0, cfg_r.ramp_limit_half};
      REG_DECEL_DIST: prdata = {16'd0, cfg_r.decel_distance};
      REG_DIR_INV:    prdata = {31'd0, cfg_r.dir_invert};
      default:        prdata = '0;
    endcase
  end

endmodule

/* sv/srsg_slot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_slot
// Evaluates one slot: step decision, ramp update, period and next state.
// ----------------------------------------------------------------------------
module srsg_slot import srsg_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  in_item_t                      item,
  input  cfg_t                          cfg,
  input  logic [POSITION_BITS-1:0]      pos,
  input  logic [POSITION_BITS-1:0]      tgt,
  input  logic signed [RAMP_BITS-1:0]   ramp,
  input  logic                          done,
  output logic [POSITION_BITS-1:0]      pos_nxt,
  output logic [POSITION_BITS-1:0]      tgt_nxt,
  output logic signed [RAMP_BITS-1:0]   ramp_nxt,
  output logic                          done_nxt,
  output out_item_t                     res
);

  localparam int PB = POSITION_BITS;

  logic [PB-1:0]                val_p;
  logic signed [PB:0]           diff_tp;
  logic signed [PB:0]           diff_pt;
  logic [PB:0]                  dist_abs;
  logic                         at_target;
  logic                         pos_minus;
  logic                         far;
  logic                         reach;
  logic                         go;
  logic                         minus;
  logic                         blocked;
  logic signed [RAMP_BITS:0]    ramp_ext;
  logic signed [RAMP_BITS:0]    limit_ext;
  logic                         up_ok;
  logic                         dn_ok;
  logic signed [RAMP_BITS+1:0]  twice_half;
  logic [HALF_BITS-1:0]         half_c;
  logic                         step_c;
  logic                         dir_c;
  logic [HALF_BITS-1:0]         half_o;

  // Operand value wrapped or sign-extended to the position width.
  assign val_p = PB'(item.value);

  // Distance to target in both senses; only one is positive in a move.
  assign diff_tp   = $signed({tgt[PB-1], tgt}) - $signed({pos[PB-1], pos});
  assign diff_pt   = $signed({pos[PB-1], pos}) - $signed({tgt[PB-1], tgt});
  assign at_target = (pos == tgt);
  assign pos_minus = diff_tp[PB];
  assign dist_abs  = pos_minus ? diff_pt : diff_tp;
  // Remaining steps after this one are dist_abs - 1.
  assign far       = dist_abs > (PB+1)'(cfg.decel_distance);
  assign reach     = dist_abs == (PB+1)'(1);

  // Ramp limits.
  assign ramp_ext  = {ramp[RAMP_BITS-1], ramp};
  assign limit_ext = $signed({3'b000, cfg.ramp_limit_half});
  assign up_ok     = (ramp_ext <= limit_ext) && (ramp != RAMP_MAX);
  assign dn_ok     = ramp != RAMP_MIN;

  // Half period from the ramp before this slot, in doubled units.
  assign twice_half = $signed({3'b000, cfg.base_half_period, 1'b0}) -
                      $signed({{2{ramp[RAMP_BITS-1]}}, ramp});

  always_comb begin
    if (twice_half[RAMP_BITS+1] || (twice_half == '0)) begin
      half_c = '0;
    end else if (twice_half[RAMP_BITS:RAMP_BITS-1] != 2'b00) begin
      half_c = '1;
    end else begin
      half_c = twice_half[HALF_BITS:1];
    end
  end

  // Direction of travel and whether the slot wants to move.
  always_comb begin
    unique case (item.op)
      OP_POSITION: begin
        go    = !at_target;
        minus = pos_minus;
      end
      OP_JOG: begin
        go    = item.jog_hold;
        minus = item.jog_dir;
      end
      default: begin
        go    = 1'b0;
        minus = 1'b0;
      end
    endcase
  end

  assign blocked = minus ? item.limit_minus : item.limit_plus;

  // Next state and slot outputs.
  always_comb begin
    pos_nxt  = pos;
    tgt_nxt  = tgt;
    ramp_nxt = ramp;
    done_nxt = done;
    step_c   = 1'b0;
    dir_c    = 1'b0;
    half_o   = '0;
    unique case (item.op)
      OP_LOAD: begin
        tgt_nxt  = val_p;
        ramp_nxt = '0;
        done_nxt = 1'b0;
      end
      OP_SETPOS: begin
        pos_nxt = val_p;
      end
      OP_POSITION, OP_JOG: begin
        if (!done) begin
          if (!go || blocked) begin
            done_nxt = 1'b1;
          end else begin
            step_c  = 1'b1;
            dir_c   = minus ^ cfg.dir_invert;
            half_o  = half_c;
            pos_nxt = minus ? (pos - PB'(1)) : (pos + PB'(1));
            if (item.op == OP_POSITION) begin
              if (far) begin
                if (up_ok) ramp_nxt = ramp + RAMP_BITS'(1);
              end else begin
                if (dn_ok) ramp_nxt = ramp - RAMP_BITS'(1);
              end
              if (reach) done_nxt = 1'b1;
            end else if (up_ok) begin
              ramp_nxt = ramp + RAMP_BITS'(1);
            end
          end
        end
      end
      default: begin
        pos_nxt = pos;
      end
    endcase
  end

  assign res.step        = step_c;
  assign res.direction   = dir_c;
  assign res.half_period = half_o;
  assign res.position    = 32'(pos_nxt);
  assign res.done_res    = done_nxt;

endmodule
